// ----- hw/rtl/adc_channel_block_statistics_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ADC channel block statistics checker
// ----------------------------------------------------------------------------
`ifndef ADC_CHANNEL_BLOCK_STATISTICS_MACROS_SVH
`define ADC_CHANNEL_BLOCK_STATISTICS_MACROS_SVH

// same-cycle implication
`define ACBS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acbs assertion failed");

// next-cycle implication
`define ACBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("acbs assertion failed");

`endif

// ----- hw/rtl/acbs_pkg.sv -----
// ----------------------------------------------------------------------------
// acbs_pkg
// Shared constants for the ADC channel block statistics block.
// ----------------------------------------------------------------------------
package acbs_pkg;
  localparam int unsigned MaxChannels = 16;
  localparam int unsigned MaxSamples  = 1024;
  localparam int unsigned ChW         = 4;
  localparam int unsigned SmpW        = 12;
  localparam int unsigned CntChW      = 5;
  localparam int unsigned CntSmpW     = 11;
  localparam int unsigned SumW        = 22;
  localparam int unsigned SqW         = 34;
  localparam int unsigned QW          = 16;
  localparam int unsigned DivW        = 42;
  localparam int unsigned RootW       = 21;
  localparam int unsigned InW         = 16;
  localparam int unsigned OutW        = 64;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 11;

  localparam logic [CfgIdxW-1:0] RegChannelCount = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSamplesPer   = 2'd1;

  localparam logic [CntChW-1:0]  ChResetVal  = 5'd16;
  localparam logic [CntSmpW-1:0] SmpResetVal = 11'd256;
endpackage

// ----- hw/rtl/adc_channel_block_statistics.sv -----
// Each input word is captured, then the entry of its channel is updated.
// After the final word of a block each channel result is computed in turn: a
// load, two 42-step divisions and a 21-step square root on one shared unit.
// A word is accepted only in the idle state; s_axis_tready is low while busy.
// Reset: asynchronous active-low; positions and error clear, registers reload.
// ----------------------------------------------------------------------------
// adc_channel_block_statistics
// Per-channel min, max, mean and RMS over blocks of interleaved ADC words.
// ----------------------------------------------------------------------------
module adc_channel_block_statistics (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [acbs_pkg::InW-1:0]        s_axis_tdata,   // raw_word
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // channel, minimum, maximum, mean_q4, rms_q4, zero pad
  output logic [acbs_pkg::OutW-1:0]       m_axis_tdata,
  output logic                            m_axis_tuser,   // block_ok
  output logic                            m_axis_tlast,   // last
  input  logic                            cfg_we_i,
  input  logic [acbs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [acbs_pkg::CfgDataW-1:0]   cfg_data_i
);
  import acbs_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_LOAD = 3'd5;

  localparam logic [5:0] DivLast  = 6'(DivW - 1);
  localparam logic [5:0] SqrtLast = 6'(RootW - 1);

  logic [2:0]          state_q, state_d;
  logic [CntChW-1:0]   nch_cfg_q;
  logic [CntSmpW-1:0]  nsm_cfg_q;
  logic [ChW-1:0]      ch_pos_q;
  logic [9:0]          smp_pos_q;
  logic                tag_err_q;
  logic [SmpW-1:0]     smp_q;
  logic [ChW-1:0]      k_q;
  logic [5:0]          cnt_q;
  logic                div_sel_q;
  logic [DivW-1:0]     dq_q;
  logic [CntSmpW-1:0]  rem_q;
  logic [RootW-1:0]    root_q;
  logic [RootW+1:0]    srem_q;
  logic [QW-1:0]       mean_q;

  logic [SmpW-1:0]     min_mem [MaxChannels];
  logic [SmpW-1:0]     max_mem [MaxChannels];
  logic [SumW-1:0]     sum_mem [MaxChannels];
  logic [SqW-1:0]      sq_mem  [MaxChannels];

  logic [CntChW-1:0]   nch;
  logic [CntSmpW-1:0]  nsm;
  logic [ChW-1:0]      idx;
  logic                first_smp;
  logic                ch_wrap;
  logic                blk_end;
  logic [SqW-1:0]      prod;
  logic [CntSmpW:0]    rem_sh;
  logic                div_ge;
  logic [RootW+1:0]    r2;
  logic [RootW+1:0]    trial;
  logic                sq_ge;
  logic                out_fire;
  logic                cfg_hit;

  always_comb begin
    if (nch_cfg_q == '0) nch = CntChW'(1);
    else if (nch_cfg_q > CntChW'(MaxChannels)) nch = CntChW'(MaxChannels);
    else nch = nch_cfg_q;
    if (nsm_cfg_q == '0) nsm = CntSmpW'(1);
    else if (nsm_cfg_q > CntSmpW'(MaxSamples)) nsm = CntSmpW'(MaxSamples);
    else nsm = nsm_cfg_q;
  end

  assign idx       = (state_q == S_UPD) ? ch_pos_q : k_q;
  assign first_smp = (smp_pos_q == '0);
  assign ch_wrap   = ({1'b0, ch_pos_q} + CntChW'(1)) >= nch;
  assign blk_end   = ch_wrap && (({1'b0, smp_pos_q} + CntSmpW'(1)) >= nsm);
  assign prod      = SqW'({{SmpW{1'b0}}, smp_q} * {{SmpW{1'b0}}, smp_q});

  assign rem_sh = {rem_q, dq_q[DivW-1]};
  assign div_ge = rem_sh >= {1'b0, nsm};
  assign r2     = {srem_q[RootW-1:0], dq_q[DivW-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign sq_ge  = r2 >= trial;

  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign cfg_hit  = cfg_we_i && (cfg_idx_i == RegChannelCount || cfg_idx_i == RegSamplesPer);

  assign s_axis_tready = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_UPD;
      S_UPD:  state_d = blk_end ? S_LOAD : S_IDLE;
      S_LOAD: state_d = S_DIV;
      S_DIV:  if (cnt_q == DivLast) state_d = div_sel_q ? S_SQRT : S_DIV;
      S_SQRT: if (cnt_q == SqrtLast) state_d = S_OUT;
      S_OUT: begin
        if (out_fire) state_d = m_axis_tlast ? S_IDLE : S_LOAD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      nch_cfg_q <= ChResetVal;
      nsm_cfg_q <= SmpResetVal;
      ch_pos_q  <= '0;
      smp_pos_q <= '0;
      tag_err_q <= 1'b0;
      k_q       <= '0;
      cnt_q     <= '0;
      div_sel_q <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_idx_i == RegChannelCount) nch_cfg_q <= cfg_data_i[CntChW-1:0];
      if (cfg_we_i && cfg_idx_i == RegSamplesPer) nsm_cfg_q <= cfg_data_i;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tdata[InW-1 -: ChW] != ch_pos_q) tag_err_q <= 1'b1;
          if (cfg_hit) begin
            ch_pos_q  <= '0;
            smp_pos_q <= '0;
            tag_err_q <= 1'b0;
          end
        end
        S_UPD: begin
          if (ch_wrap) begin
            ch_pos_q  <= '0;
            smp_pos_q <= blk_end ? '0 : smp_pos_q + 10'd1;
          end else begin
            ch_pos_q <= ch_pos_q + ChW'(1);
          end
          k_q       <= '0;
          cnt_q     <= '0;
          div_sel_q <= 1'b0;
        end
        S_DIV: begin
          cnt_q <= (cnt_q == DivLast) ? '0 : cnt_q + 6'd1;
          if (cnt_q == DivLast) div_sel_q <= ~div_sel_q;
        end
        S_SQRT: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == SqrtLast) m_axis_tvalid <= 1'b1;
        end
        S_OUT: begin
          if (out_fire) begin
            m_axis_tvalid <= 1'b0;
            k_q   <= k_q + ChW'(1);
            cnt_q <= '0;
            if (m_axis_tlast) tag_err_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath: word capture, channel entry update, shared divide / root unit
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) smp_q <= s_axis_tdata[SmpW-1:0];
    if (state_q == S_UPD) begin
      if (first_smp || smp_q < min_mem[idx]) min_mem[idx] <= smp_q;
      if (first_smp || smp_q > max_mem[idx]) max_mem[idx] <= smp_q;
      sum_mem[idx] <= first_smp ? SumW'(smp_q) : sum_mem[idx] + SumW'(smp_q);
      sq_mem[idx]  <= first_smp ? prod : sq_mem[idx] + prod;
    end
    case (state_q)
      S_LOAD: begin
        dq_q  <= DivW'({sum_mem[idx], 4'b0});
        rem_q <= '0;
      end
      S_DIV: begin
        if (cnt_q == DivLast && !div_sel_q) begin
          mean_q <= {dq_q[QW-2:0], div_ge};
          dq_q   <= {sq_mem[idx], 8'b0};
          rem_q  <= '0;
        end else begin
          dq_q  <= {dq_q[DivW-2:0], div_ge};
          rem_q <= div_ge ? CntSmpW'(rem_sh - {1'b0, nsm}) : rem_sh[CntSmpW-1:0];
        end
        if (cnt_q == DivLast && div_sel_q) begin
          root_q <= '0;
          srem_q <= '0;
        end
      end
      S_SQRT: begin
        dq_q   <= {dq_q[DivW-3:0], 2'b00};
        srem_q <= sq_ge ? r2 - trial : r2;
        root_q <= {root_q[RootW-2:0], sq_ge};
        if (cnt_q == SqrtLast) begin
          m_axis_tdata <= {4'b0, root_q[QW-2:0], sq_ge, mean_q,
                           max_mem[idx], min_mem[idx], k_q};
          m_axis_tuser <= ~tag_err_q;
          m_axis_tlast <= ({1'b0, k_q} + CntChW'(1)) == nch;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/acbs_checker.sv -----
// ----------------------------------------------------------------------------
// acbs_checker
// Port-level checks on the ADC channel block statistics block.
// ----------------------------------------------------------------------------
`include "adc_channel_block_statistics_macros.svh"

module acbs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast
);
  `ACBS_ASSERT_IMPL(a_no_in_while_out, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready)
  `ACBS_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `ACBS_ASSERT_NEXT(a_gap_after_out, clk_i, rst_ni, m_axis_tvalid && m_axis_tready, !m_axis_tvalid)
  `ACBS_ASSERT_NEXT(a_out_held, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tlast))
endmodule

bind adc_channel_block_statistics acbs_checker u_acbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tlast  (m_axis_tlast)
);
